[sv/pulse_height_histogram_peak_finder_defines.svh]
// assertion macros for the pulse height histogram blocks
// expects clk and rst in the scope of every use
`ifndef PULSE_HEIGHT_HISTOGRAM_PEAK_FINDER_DEFINES_SVH
`define PULSE_HEIGHT_HISTOGRAM_PEAK_FINDER_DEFINES_SVH

// same-cycle implication
`define PHHPF_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PHHPF_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/phhpf_pkg.sv]
// shared types, codes and constants of the pulse height histogram block
// no dependencies
package phhpf_pkg;

  localparam int MAX_CHANNELS = 4;
  localparam int CH_W         = 2;
  localparam int KIND_W       = 2;
  localparam int AMP_W        = 14;
  localparam int AMP_MAG_W    = 13;
  localparam int CUT_W        = 13;
  localparam int BIN_W        = 7;
  localparam int EDGE_W       = 13;
  localparam int REG_IDX_W    = 3;

  localparam int DEF_NUM_CHANNELS   = 4;
  localparam int DEF_NUM_BINS       = 100;
  localparam int DEF_BIN_STEP       = 28;
  localparam int DEF_FIRST_SCAN_BIN = 8;
  localparam int DEF_LAST_SCAN_BIN  = 100;
  localparam int DEF_COUNT_WIDTH    = 24;
  localparam int LOW_STAT_LIMIT     = 5;

  localparam logic [KIND_W-1:0] KIND_FILL   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REPORT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_LOWER_CUT_0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_UPPER_CUT_0 = 3'd4;

  typedef logic [CUT_W-1:0] cut_t;
  typedef logic signed [AMP_W-1:0] amp_t;

  localparam cut_t LOWER_CUT_RST [MAX_CHANNELS] = '{13'd640, 13'd560, 13'd800, 13'd240};
  localparam cut_t UPPER_CUT_RST [MAX_CHANNELS] = '{13'd1200, 13'd1280, 13'd1760, 13'd2800};

  typedef struct packed {
    logic            busy;
    logic            acc_inc;
    logic [CH_W-1:0] acc_ch;
  } fill_status_t;

  typedef struct packed {
    logic            busy;
    logic            row_valid;
    logic            row_last;
    logic [CH_W-1:0] row_ch;
  } scan_status_t;

endpackage

[sv/phhpf_ram.sv]
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module phhpf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 400
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/phhpf_fill.sv]
// fill pipeline: window check, bin by reciprocal multiply, read-modify-write
// depends on phhpf_pkg and the assertion macro header
`include "pulse_height_histogram_peak_finder_defines.svh"

module phhpf_fill import phhpf_pkg::*; #(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
  parameter int NUM_BINS     = DEF_NUM_BINS,
  parameter int BIN_STEP     = DEF_BIN_STEP,
  parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH,
  parameter int ADDR_W       = 9
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  amp_t                   amps [MAX_CHANNELS],
  input  cut_t                   lower_cut [MAX_CHANNELS],
  input  cut_t                   upper_cut [MAX_CHANNELS],
  output fill_status_t           status,
  output logic                   rd_en,
  output logic [ADDR_W-1:0]      rd_addr,
  input  logic [COUNT_WIDTH-1:0] rd_data,
  output logic                   wr_en,
  output logic [ADDR_W-1:0]      wr_addr,
  output logic [COUNT_WIDTH-1:0] wr_data
);

  localparam int DIV_SHIFT = AMP_MAG_W + $clog2(BIN_STEP);
  localparam int RECIP     = (2 ** DIV_SHIFT + BIN_STEP - 1) / BIN_STEP;
  localparam int PROD_W    = DIV_SHIFT + AMP_MAG_W;

  amp_t amp_q [MAX_CHANNELS];
  logic issue;
  logic [CH_W-1:0] iss_ch;

  amp_t amp_sel;
  logic [AMP_MAG_W-1:0] mag;
  logic in_win;

  logic s1_valid;
  logic s1_win;
  logic [CH_W-1:0] s1_ch;
  logic [PROD_W-1:0] s1_prod;
  logic [AMP_MAG_W-1:0] quot;
  logic hit;

  logic s2_valid;
  logic [ADDR_W-1:0] s2_addr;

  always_ff @(posedge clk) begin
    if (start) begin
      amp_q <= amps;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue  <= 1'b0;
      iss_ch <= '0;
    end else if (start) begin
      issue  <= 1'b1;
      iss_ch <= '0;
    end else if (issue) begin
      if (iss_ch == CH_W'(NUM_CHANNELS - 1)) begin
        issue <= 1'b0;
      end else begin
        iss_ch <= iss_ch + CH_W'(1);
      end
    end
  end

  // stage 0: window and reciprocal product
  assign amp_sel = amp_q[iss_ch];
  assign mag     = amp_sel[AMP_MAG_W-1:0];
  assign in_win  = !amp_sel[AMP_W-1] && (mag >= lower_cut[iss_ch]) &&
                   (mag <= upper_cut[iss_ch]);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    s1_win  <= in_win;
    s1_ch   <= iss_ch;
    s1_prod <= PROD_W'(mag) * PROD_W'(RECIP);
  end

  // stage 1: bin index, counter read
  assign quot    = s1_prod[DIV_SHIFT +: AMP_MAG_W];
  assign hit     = s1_valid && s1_win && (quot < AMP_MAG_W'(NUM_BINS));
  assign rd_en   = hit;
  assign rd_addr = ADDR_W'(s1_ch) * ADDR_W'(NUM_BINS) + ADDR_W'(quot);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= hit;
    end
  end

  always_ff @(posedge clk) begin
    s2_addr <= rd_addr;
  end

  // stage 2: saturating increment, write back
  assign wr_en   = s2_valid;
  assign wr_addr = s2_addr;
  assign wr_data = (rd_data == '1) ? rd_data : rd_data + COUNT_WIDTH'(1);

  assign status.busy    = issue || s1_valid || s2_valid;
  assign status.acc_inc = s1_valid && s1_win;
  assign status.acc_ch  = s1_ch;

  `PHHPF_ASSERT_NEXT(a_fill_writes_back, rd_en, wr_en && (wr_addr == $past(rd_addr)),
    "fill read not written back on the next cycle")
  `PHHPF_ASSERT_IMPL(a_fill_start_idle, start, !status.busy,
    "fill started while a previous fill is in flight")
  `PHHPF_ASSERT_IMPL(a_fill_channel_range, status.acc_inc,
    status.acc_ch <= CH_W'(NUM_CHANNELS - 1), "fill channel out of range")

endmodule

[sv/phhpf_scan.sv]
// peak scan: walks the bins of each channel and keeps the first largest count
// depends on phhpf_pkg and the assertion macro header
`include "pulse_height_histogram_peak_finder_defines.svh"

module phhpf_scan import phhpf_pkg::*; #(
  parameter int NUM_CHANNELS   = DEF_NUM_CHANNELS,
  parameter int NUM_BINS       = DEF_NUM_BINS,
  parameter int BIN_STEP       = DEF_BIN_STEP,
  parameter int FIRST_SCAN_BIN = DEF_FIRST_SCAN_BIN,
  parameter int LAST_SCAN_BIN  = DEF_LAST_SCAN_BIN,
  parameter int COUNT_WIDTH    = DEF_COUNT_WIDTH,
  parameter int ADDR_W         = 9
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output scan_status_t             status,
  input  logic                     row_ready,
  output logic [BIN_W-1:0]         row_bin,
  output logic signed [EDGE_W-1:0] row_edge,
  output logic [COUNT_WIDTH-1:0]   row_count,
  output logic                     rd_en,
  output logic [ADDR_W-1:0]        rd_addr,
  input  logic [COUNT_WIDTH-1:0]   rd_data
);

  localparam int SCAN_LO     = (FIRST_SCAN_BIN < 1) ? 1 : FIRST_SCAN_BIN;
  localparam int SCAN_HI     = (LAST_SCAN_BIN > NUM_BINS) ? NUM_BINS : LAST_SCAN_BIN;
  localparam bit SCAN_EMPTY  = SCAN_LO > SCAN_HI;
  localparam int EDGE_FULL_W = BIN_W + 12;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_TAIL = 2'd2;
  localparam logic [1:0] S_ROW  = 2'd3;

  logic [1:0] state;
  logic [CH_W-1:0] ch;
  logic [BIN_W-1:0] bin;
  logic cmp_valid;
  logic [BIN_W-1:0] cmp_bin;
  logic [COUNT_WIDTH-1:0] best;
  logic [BIN_W-1:0] best_bin;
  logic last_ch;
  logic signed [BIN_W:0] bin_m1;
  logic signed [EDGE_FULL_W-1:0] edge_full;

  assign last_ch = (ch == CH_W'(NUM_CHANNELS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ch        <= '0;
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= (state == S_READ);
      case (state)
        S_IDLE: begin
          if (start) begin
            ch    <= '0;
            state <= SCAN_EMPTY ? S_ROW : S_READ;
          end
        end
        S_READ: begin
          if (bin == BIN_W'(SCAN_HI)) begin
            state <= S_TAIL;
          end
        end
        S_TAIL: begin
          state <= S_ROW;
        end
        S_ROW: begin
          if (row_ready) begin
            if (last_ch) begin
              state <= S_IDLE;
            end else begin
              ch    <= ch + CH_W'(1);
              state <= SCAN_EMPTY ? S_ROW : S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // bin walk and running maximum
  always_ff @(posedge clk) begin
    if ((state == S_IDLE && start) || (state == S_ROW && row_ready)) begin
      bin      <= BIN_W'(SCAN_LO);
      best     <= '0;
      best_bin <= '0;
    end else begin
      if (state == S_READ) begin
        bin <= bin + BIN_W'(1);
      end
      if (cmp_valid && (rd_data > best)) begin
        best     <= rd_data;
        best_bin <= cmp_bin;
      end
    end
    cmp_bin <= bin;
  end

  assign rd_en   = (state == S_READ);
  assign rd_addr = ADDR_W'(ch) * ADDR_W'(NUM_BINS) + ADDR_W'(bin - BIN_W'(1));

  assign bin_m1    = $signed({1'b0, best_bin}) - $signed((BIN_W + 1)'(1));
  assign edge_full = EDGE_FULL_W'(bin_m1) * $signed(EDGE_FULL_W'(BIN_STEP));

  assign row_bin   = best_bin;
  assign row_count = best;
  assign row_edge  = edge_full[EDGE_W-1:0];

  assign status.busy      = (state != S_IDLE);
  assign status.row_valid = (state == S_ROW);
  assign status.row_last  = last_ch;
  assign status.row_ch    = ch;

  `PHHPF_ASSERT_IMPL(a_scan_start_idle, start, !status.busy,
    "scan started while a report is running")
  `PHHPF_ASSERT_IMPL(a_scan_peak_range, status.row_valid,
    (best_bin == '0) || ((best_bin >= BIN_W'(SCAN_LO)) && (best_bin <= BIN_W'(SCAN_HI))),
    "peak bin outside the scan range")
  `PHHPF_ASSERT_NEXT(a_scan_ends_after_last,
    status.row_valid && row_ready && status.row_last, !status.busy,
    "scan still running after the last row")

endmodule

[sv/pulse_height_histogram_peak_finder.sv]
// pulse height histogram with peak finder, top level
// depends on phhpf_pkg, phhpf_ram, phhpf_fill, phhpf_scan and the macro header
//
// input channel (in_valid/in_stall) takes one item per transfer: kind selects
// fill, report or clear, and kind 3 is taken and does nothing. a fill sends
// one channel per cycle through window check, reciprocal multiply and a
// read-modify-write of the shared count ram. a report scans the ram one bin a
// cycle, walking the scan range of each channel in turn, and
// emits one row per channel in channel order; last marks the final row.
// rows sit in an output register, so the next item is taken while a row waits;
// a stalled output holds the row and the scan waits on the next one.
// a clear zeroes the fill counts at once and then sweeps every entry of the
// ram, one entry a cycle, stalling input.
// reset runs the same sweep before the first item is taken.
// the cut registers (cfg_valid/cfg_ready, index 0..3 lower, 4..7 upper) are
// always ready and reset to their nominal values.
`include "pulse_height_histogram_peak_finder_defines.svh"

module pulse_height_histogram_peak_finder import phhpf_pkg::*; #(
  parameter int NUM_CHANNELS   = DEF_NUM_CHANNELS,
  parameter int NUM_BINS       = DEF_NUM_BINS,
  parameter int BIN_STEP       = DEF_BIN_STEP,
  parameter int FIRST_SCAN_BIN = DEF_FIRST_SCAN_BIN,
  parameter int LAST_SCAN_BIN  = DEF_LAST_SCAN_BIN,
  parameter int COUNT_WIDTH    = DEF_COUNT_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [REG_IDX_W-1:0]     cfg_index,
  input  logic [CUT_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [KIND_W-1:0]        kind,
  input  logic signed [AMP_W-1:0]  amplitude_0,
  input  logic signed [AMP_W-1:0]  amplitude_1,
  input  logic signed [AMP_W-1:0]  amplitude_2,
  input  logic signed [AMP_W-1:0]  amplitude_3,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [CH_W-1:0]          channel,
  output logic [BIN_W-1:0]         peak_bin,
  output logic signed [EDGE_W-1:0] peak_edge,
  output logic [COUNT_WIDTH-1:0]   peak_count,
  output logic [COUNT_WIDTH-1:0]   fill_count,
  output logic                     low_statistics,
  output logic                     last
);

  localparam int DEPTH  = NUM_CHANNELS * NUM_BINS;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [1:0] ST_SWEEP = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_FILL  = 2'd2;
  localparam logic [1:0] ST_SCAN  = 2'd3;

  logic [1:0] state;
  logic [ADDR_W-1:0] sweep_addr;

  cut_t lower_cut [MAX_CHANNELS];
  cut_t upper_cut [MAX_CHANNELS];
  logic [COUNT_WIDTH-1:0] accepted [MAX_CHANNELS];
  amp_t amps [MAX_CHANNELS];

  logic in_accept;
  logic fill_start;
  logic scan_start;
  logic clear_start;

  fill_status_t fill_st;
  scan_status_t scan_st;

  logic fill_rd_en;
  logic [ADDR_W-1:0] fill_rd_addr;
  logic fill_wr_en;
  logic [ADDR_W-1:0] fill_wr_addr;
  logic [COUNT_WIDTH-1:0] fill_wr_data;

  logic scan_rd_en;
  logic [ADDR_W-1:0] scan_rd_addr;
  logic [BIN_W-1:0] row_bin;
  logic signed [EDGE_W-1:0] row_edge;
  logic [COUNT_WIDTH-1:0] row_count;
  logic row_ready;
  logic row_take;

  logic ram_wr_en;
  logic [ADDR_W-1:0] ram_wr_addr;
  logic [COUNT_WIDTH-1:0] ram_wr_data;
  logic ram_rd_en;
  logic [ADDR_W-1:0] ram_rd_addr;
  logic [COUNT_WIDTH-1:0] ram_rd_data;

  logic [COUNT_WIDTH-1:0] row_fill;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_cut <= LOWER_CUT_RST;
      upper_cut <= UPPER_CUT_RST;
    end else if (cfg_valid) begin
      if (cfg_index < REG_UPPER_CUT_0) begin
        lower_cut[cfg_index[CH_W-1:0]] <= cfg_data;
      end else begin
        upper_cut[cfg_index[CH_W-1:0]] <= cfg_data;
      end
    end
  end

  // input transfer and sequencing
  assign in_stall = !((state == ST_IDLE) ||
                      (state == ST_FILL && !fill_st.busy) ||
                      (state == ST_SCAN && !scan_st.busy));
  assign in_accept   = in_valid && !in_stall;
  assign fill_start  = in_accept && (kind == KIND_FILL);
  assign scan_start  = in_accept && (kind == KIND_REPORT);
  assign clear_start = in_accept && (kind == KIND_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      sweep_addr <= '0;
    end else if (in_accept) begin
      case (kind)
        KIND_FILL:   state <= ST_FILL;
        KIND_REPORT: state <= ST_SCAN;
        KIND_CLEAR: begin
          state      <= ST_SWEEP;
          sweep_addr <= '0;
        end
        default:     state <= ST_IDLE;
      endcase
    end else begin
      case (state)
        ST_SWEEP: begin
          if (sweep_addr == ADDR_W'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end else begin
            sweep_addr <= sweep_addr + ADDR_W'(1);
          end
        end
        ST_FILL: begin
          if (!fill_st.busy) begin
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (!scan_st.busy) begin
            state <= ST_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  // per-channel accepted amplitude counts
  always_ff @(posedge clk) begin
    if (rst || clear_start) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        accepted[i] <= '0;
      end
    end else if (fill_st.acc_inc && (accepted[fill_st.acc_ch] != '1)) begin
      accepted[fill_st.acc_ch] <= accepted[fill_st.acc_ch] + COUNT_WIDTH'(1);
    end
  end

  assign amps[0] = amplitude_0;
  assign amps[1] = amplitude_1;
  assign amps[2] = amplitude_2;
  assign amps[3] = amplitude_3;

  phhpf_fill #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .NUM_BINS     (NUM_BINS),
    .BIN_STEP     (BIN_STEP),
    .COUNT_WIDTH  (COUNT_WIDTH),
    .ADDR_W       (ADDR_W)
  ) u_fill (
    .clk       (clk),
    .rst       (rst),
    .start     (fill_start),
    .amps      (amps),
    .lower_cut (lower_cut),
    .upper_cut (upper_cut),
    .status    (fill_st),
    .rd_en     (fill_rd_en),
    .rd_addr   (fill_rd_addr),
    .rd_data   (ram_rd_data),
    .wr_en     (fill_wr_en),
    .wr_addr   (fill_wr_addr),
    .wr_data   (fill_wr_data)
  );

  phhpf_scan #(
    .NUM_CHANNELS   (NUM_CHANNELS),
    .NUM_BINS       (NUM_BINS),
    .BIN_STEP       (BIN_STEP),
    .FIRST_SCAN_BIN (FIRST_SCAN_BIN),
    .LAST_SCAN_BIN  (LAST_SCAN_BIN),
    .COUNT_WIDTH    (COUNT_WIDTH),
    .ADDR_W         (ADDR_W)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (scan_start),
    .status    (scan_st),
    .row_ready (row_ready),
    .row_bin   (row_bin),
    .row_edge  (row_edge),
    .row_count (row_count),
    .rd_en     (scan_rd_en),
    .rd_addr   (scan_rd_addr),
    .rd_data   (ram_rd_data)
  );

  // count ram ports
  assign ram_wr_en   = (state == ST_SWEEP) || fill_wr_en;
  assign ram_wr_addr = (state == ST_SWEEP) ? sweep_addr : fill_wr_addr;
  assign ram_wr_data = (state == ST_SWEEP) ? '0 : fill_wr_data;
  assign ram_rd_en   = fill_rd_en || scan_rd_en;
  assign ram_rd_addr = scan_rd_en ? scan_rd_addr : fill_rd_addr;

  phhpf_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (DEPTH)
  ) u_counts (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // output register
  assign row_ready = !out_valid || !out_stall;
  assign row_take  = scan_st.row_valid && row_ready;
  assign row_fill  = accepted[scan_st.row_ch];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (row_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (row_take) begin
      channel        <= scan_st.row_ch;
      peak_bin       <= row_bin;
      peak_edge      <= row_edge;
      peak_count     <= row_count;
      fill_count     <= row_fill;
      low_statistics <= (row_fill < COUNT_WIDTH'(LOW_STAT_LIMIT));
      last           <= scan_st.row_last;
    end
  end

  `PHHPF_ASSERT_IMPL(a_single_reader, fill_rd_en, !scan_rd_en,
    "fill and scan read the count ram together")
  `PHHPF_ASSERT_IMPL(a_sweep_quiet, state == ST_SWEEP, !fill_wr_en && !scan_rd_en,
    "count ram used during the clearing sweep")
  `PHHPF_ASSERT_NEXT(a_clear_sweeps, clear_start,
    (state == ST_SWEEP) && (sweep_addr == '0), "clear did not restart the sweep")

endmodule

[bench/pulse_height_histogram_peak_finder_checker.sv]
// checker for the pulse height histogram: tracks the cut registers and the bin tallies,
// predicts every report row and compares it with what the block sends out
// depends on phhpf_pkg
module pulse_height_histogram_peak_finder_checker import phhpf_pkg::*; #(
  parameter int COUNT_W = DEF_COUNT_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [REG_IDX_W-1:0]     cfg_index,
  input  logic [CUT_W-1:0]         cfg_data,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [KIND_W-1:0]        kind,
  input  amp_t                     amplitude_0,
  input  amp_t                     amplitude_1,
  input  amp_t                     amplitude_2,
  input  amp_t                     amplitude_3,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [CH_W-1:0]          channel,
  input  logic [BIN_W-1:0]         peak_bin,
  input  logic signed [EDGE_W-1:0] peak_edge,
  input  logic [COUNT_W-1:0]       peak_count,
  input  logic [COUNT_W-1:0]       fill_count,
  input  logic                     low_statistics,
  input  logic                     last,
  output int                       mismatch_count,
  output int                       rows_due,
  output int                       rows_checked
);

  localparam int NCH   = DEF_NUM_CHANNELS;
  localparam int NBINS = DEF_NUM_BINS;

  typedef struct packed {
    logic [CH_W-1:0]          ch;
    logic [BIN_W-1:0]         bin;
    logic signed [EDGE_W-1:0] lo_edge;
    logic [COUNT_W-1:0]       peak;
    logic [COUNT_W-1:0]       fills;
    logic                     low_stat;
    logic                     is_last;
  } peak_row_t;

  logic [COUNT_W-1:0] bin_tally [NCH][1:NBINS];
  logic [COUNT_W-1:0] hit_tally [NCH];
  cut_t               lower_cut [NCH];
  cut_t               upper_cut [NCH];
  peak_row_t          peak_rows_due [$];

  function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  task automatic clear_tallies();
    for (int c = 0; c < NCH; c++) begin
      hit_tally[c] = '0;
      for (int b = 1; b <= NBINS; b++) bin_tally[c][b] = '0;
    end
  endtask

  task automatic fill_event(input amp_t amps [NCH]);
    int a;
    int b;
    for (int c = 0; c < NCH; c++) begin
      a = amps[c];
      if (a < int'(lower_cut[c]) || a > int'(upper_cut[c])) continue;
      hit_tally[c] = bump(hit_tally[c]);
      b = a / DEF_BIN_STEP + 1;
      // accepted but past the last bin: only the fill count moves
      if (b >= 1 && b <= NBINS) bin_tally[c][b] = bump(bin_tally[c][b]);
    end
  endtask

  task automatic queue_peaks();
    peak_row_t          row;
    logic [COUNT_W-1:0] best;
    int                 best_bin;
    for (int c = 0; c < NCH; c++) begin
      best     = '0;
      best_bin = 0;
      for (int b = DEF_FIRST_SCAN_BIN; b <= DEF_LAST_SCAN_BIN; b++) begin
        if (b >= 1 && b <= NBINS && bin_tally[c][b] > best) begin
          best     = bin_tally[c][b];
          best_bin = b;
        end
      end
      row.ch       = CH_W'(c);
      row.bin      = BIN_W'(best_bin);
      row.lo_edge  = EDGE_W'((best_bin - 1) * DEF_BIN_STEP);
      row.peak     = best;
      row.fills    = hit_tally[c];
      row.low_stat = hit_tally[c] < LOW_STAT_LIMIT;
      row.is_last  = (c == NCH - 1);
      peak_rows_due.push_back(row);
    end
  endtask

  always @(posedge clk) begin
    peak_row_t want;
    peak_row_t got;
    if (rst) begin
      for (int c = 0; c < NCH; c++) begin
        lower_cut[c] = LOWER_CUT_RST[c];
        upper_cut[c] = UPPER_CUT_RST[c];
      end
      clear_tallies();
      peak_rows_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index >= REG_UPPER_CUT_0) upper_cut[cfg_index - REG_UPPER_CUT_0] = cfg_data;
        else lower_cut[cfg_index - REG_LOWER_CUT_0] = cfg_data;
      end
      if (in_valid && !in_stall) begin
        case (kind)
          KIND_FILL: begin
            fill_event('{amplitude_0, amplitude_1, amplitude_2, amplitude_3});
          end
          KIND_REPORT: begin
            queue_peaks();
          end
          KIND_CLEAR: begin
            clear_tallies();
          end
          default: begin
          end
        endcase
      end
      if (out_valid && !out_stall) begin
        got = '{channel, peak_bin, peak_edge, peak_count, fill_count, low_statistics, last};
        if (peak_rows_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("row transfer with no report pending: channel %0d bin %0d count %0d",
                     channel, peak_bin, peak_count);
        end else begin
          want = peak_rows_due.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("row %0d expected: ch %0d bin %0d edge %0d peak %0d fills %0d low %0b last %0b",
                       rows_checked, want.ch, want.bin, want.lo_edge, want.peak, want.fills,
                       want.low_stat, want.is_last);
              $display("row %0d actual:   ch %0d bin %0d edge %0d peak %0d fills %0d low %0b last %0b",
                       rows_checked, got.ch, got.bin, got.lo_edge, got.peak, got.fills,
                       got.low_stat, got.is_last);
            end
          end
        end
        rows_checked++;
      end
    end
    rows_due = peak_rows_due.size();
  end

endmodule

[bench/pulse_height_histogram_peak_finder_tb.sv]
// testbench top for the pulse height histogram: drives events, reports and clears
// over several cut settings with random pacing, and gives the verdict
// depends on phhpf_pkg, the block and pulse_height_histogram_peak_finder_checker
module pulse_height_histogram_peak_finder_tb;
  import phhpf_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int NCH           = DEF_NUM_CHANNELS;
  localparam int SETTLE_CYCLES = 500;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_ITEMS  = 270;
  localparam int MIN_ROWS      = 48;

  logic                     clk;
  logic                     rst;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [REG_IDX_W-1:0]     cfg_index;
  logic [CUT_W-1:0]         cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic [KIND_W-1:0]        kind;
  amp_t                     amplitude_0;
  amp_t                     amplitude_1;
  amp_t                     amplitude_2;
  amp_t                     amplitude_3;
  logic                     out_valid;
  logic                     out_stall;
  logic [CH_W-1:0]          channel;
  logic [BIN_W-1:0]         peak_bin;
  logic signed [EDGE_W-1:0] peak_edge;
  logic [DEF_COUNT_WIDTH-1:0] peak_count;
  logic [DEF_COUNT_WIDTH-1:0] fill_count;
  logic                     low_statistics;
  logic                     last;

  int mismatch_count;
  int rows_due;
  int rows_checked;

  cut_t lo_cut [NCH];
  cut_t hi_cut [NCH];
  int   center [NCH];
  int   burst_left;
  int   cycle_count;
  int   fills_sent;
  int   reports_sent;
  int   clears_sent;
  int   spare_sent;
  int   random_sent;
  int   settings;

  pulse_height_histogram_peak_finder u_top (.*);

  pulse_height_histogram_peak_finder_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d rows still due", cycle_count, rows_due);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: free-running, light random stall, or mostly stalled
  initial begin
    int mode;
    int left;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      left = $urandom_range(20, 200);
      repeat (left) begin
        @(negedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 35);
          default: out_stall <= ($urandom_range(0, 15) != 0);
        endcase
      end
    end
  end

  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if ($urandom_range(0, 19) == 0) gap = $urandom_range(20, 40);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send(input logic [KIND_W-1:0] k, input int a0, input int a1,
                      input int a2, input int a3);
    pace();
    in_valid    <= 1'b1;
    kind        <= k;
    amplitude_0 <= amp_t'(a0);
    amplitude_1 <= amp_t'(a1);
    amplitude_2 <= amp_t'(a2);
    amplitude_3 <= amp_t'(a3);
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    case (k)
      KIND_FILL:   fills_sent++;
      KIND_REPORT: reports_sent++;
      KIND_CLEAR:  clears_sent++;
      default:     spare_sent++;
    endcase
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (rows_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_cuts();
    for (int i = 0; i < 2 * NCH; i++) begin
      cfg_valid <= 1'b1;
      if (i < NCH) begin
        cfg_index <= REG_IDX_W'(REG_LOWER_CUT_0 + i);
        cfg_data  <= lo_cut[i];
      end else begin
        cfg_index <= REG_IDX_W'(REG_UPPER_CUT_0 + i - NCH);
        cfg_data  <= hi_cut[i - NCH];
      end
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    settings++;
  endtask

  task automatic choose_cuts(input int mode);
    int span;
    for (int c = 0; c < NCH; c++) begin
      case (mode)
        0: begin
          lo_cut[c] = LOWER_CUT_RST[c];
          hi_cut[c] = UPPER_CUT_RST[c];
        end
        1: begin
          lo_cut[c] = '0;
          hi_cut[c] = '1;
        end
        2: begin
          lo_cut[c] = CUT_W'($urandom_range(0, 1500));
          hi_cut[c] = CUT_W'($urandom_range(lo_cut[c] + 100, 8191 < lo_cut[c] + 3000 ?
                                            8191 : lo_cut[c] + 3000));
        end
        default: begin
          lo_cut[c] = CUT_W'($urandom_range(0, 2900));
          hi_cut[c] = CUT_W'(lo_cut[c] + $urandom_range(0, 100));
        end
      endcase
      span = int'(hi_cut[c]) - int'(lo_cut[c]);
      if (span > 3000) span = 3000;
      center[c] = (span >= 0) ? int'(lo_cut[c]) + $urandom_range(0, span) : $urandom_range(0, 8191);
    end
  endtask

  function automatic int pick_amp(input int c);
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return center[c] + int'($urandom_range(0, 160)) - 80;
    if (r < 72) return int'(lo_cut[c]) + int'($urandom_range(0, 4)) - 2;
    if (r < 80) return int'(hi_cut[c]) + int'($urandom_range(0, 4)) - 2;
    return int'($urandom_range(0, 16383)) - 8192;
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 88) return KIND_FILL;
    if (r < 95) return KIND_REPORT;
    if (r < 97) return KIND_CLEAR;
    return KIND_SPARE;
  endfunction

  initial begin
    int phase;
    rst         = 1'b1;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    kind        = KIND_FILL;
    amplitude_0 = '0;
    amplitude_1 = '0;
    amplitude_2 = '0;
    amplitude_3 = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    choose_cuts(0);

    // nominal cuts: empty report, window edges, rails, ties, low statistics
    send(KIND_REPORT, 0, 0, 0, 0);
    send(KIND_FILL, 640, 560, 800, 240);
    send(KIND_FILL, 1200, 1280, 1760, 2800);
    send(KIND_FILL, 639, 559, 799, 239);
    send(KIND_FILL, 1201, 1281, 1761, 2801);
    send(KIND_FILL, -8192, -8192, -8192, -8192);
    send(KIND_FILL, 8191, 8191, 8191, 8191);
    send(KIND_SPARE, 700, 700, 900, 300);
    send(KIND_FILL, 700, 700, 900, 300);
    send(KIND_FILL, 900, 600, 1000, 400);
    send(KIND_FILL, 1000, 100, 1000, 100);
    send(KIND_REPORT, 0, 0, 0, 0);
    send(KIND_FILL, 0, 0, 0, 0);
    send(KIND_CLEAR, 0, 0, 0, 0);
    send(KIND_REPORT, 0, 0, 0, 0);

    // open window: first and last bins, beyond the last bin, unscanned bins
    settle();
    choose_cuts(1);
    apply_cuts();
    send(KIND_FILL, 0, 195, 196, 2799);
    send(KIND_FILL, 2800, 8191, 27, 28);
    send(KIND_FILL, -1, -8192, 8191, 2799);
    send(KIND_REPORT, 0, 0, 0, 0);

    // inverted window rejects everything
    settle();
    for (int c = 0; c < NCH; c++) begin
      lo_cut[c] = '1;
      hi_cut[c] = '0;
    end
    apply_cuts();
    send(KIND_FILL, 8191, 0, 4000, -8192);
    send(KIND_REPORT, 0, 0, 0, 0);

    // single-value window
    settle();
    for (int c = 0; c < NCH; c++) begin
      lo_cut[c] = CUT_W'(1000);
      hi_cut[c] = CUT_W'(1000);
    end
    apply_cuts();
    send(KIND_FILL, 1000, 999, 1001, 1000);
    send(KIND_REPORT, 0, 0, 0, 0);
    send(KIND_CLEAR, 0, 0, 0, 0);

    phase = 0;
    while (random_sent < RANDOM_ITEMS || reports_sent * NCH < MIN_ROWS) begin
      settle();
      choose_cuts(phase % 4);
      apply_cuts();
      repeat (45) begin
        send(pick_kind(), pick_amp(0), pick_amp(1), pick_amp(2), pick_amp(3));
        random_sent++;
      end
      phase++;
    end

    settle();
    $display("%0d fills, %0d reports, %0d clears, %0d spare-kind items over %0d cut settings",
             fills_sent, reports_sent, clears_sent, spare_sent, settings);
    $display("%0d report rows checked, %0d mismatches", rows_checked, mismatch_count);
    if (mismatch_count == 0 && rows_due == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/phhpf_pkg.sv
sv/phhpf_ram.sv
sv/phhpf_fill.sv
sv/phhpf_scan.sv
sv/pulse_height_histogram_peak_finder.sv
bench/pulse_height_histogram_peak_finder_checker.sv
bench/pulse_height_histogram_peak_finder_tb.sv
